// File: rtl/pti_pkg.sv
// Shared types and codes for the prefix tree insert and search block.
`timescale 1ns / 1ps
`default_nettype none

package pti_pkg;

  // Operation codes carried by every request
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_PREFIX = 2'd2;

  localparam int LETTER_W = 5;

  // One request: one letter of a word
  typedef struct packed {
    logic [1:0]          operation;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                empty_word;
  } req_t;

  // One result, given on the last letter of a word
  typedef struct packed {
    logic found;
    logic pool_full;
  } rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic walk;
    logic finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic item_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/pti_ctrl.sv
// Controller state machine that sequences clearing, letter steps and results.
`timescale 1ns / 1ps
`default_nettype none

module pti_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire pti_pkg::status_t  status,
  output pti_pkg::cmd_t          cmd
);
  import pti_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk   = 1'b1;
        state_next = status.item_last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/pti_datapath.sv
// Datapath: node pool memories, walk registers, allocator and result register.
`timescale 1ns / 1ps
`default_nettype none

module pti_datapath #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pti_pkg::cmd_t    cmd,
  output pti_pkg::status_t      status,
  input  wire pti_pkg::req_t    req_data,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output pti_pkg::rsp_t         rsp_data
);
  import pti_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int SLOTS  = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [NODE_W:0]   NODE_LIMIT = (NODE_W + 1)'(NODE_COUNT);
  localparam logic [SLOT_W-1:0] ALPHA_SLOT = SLOT_W'(ALPHABET_SIZE);
  localparam logic [SLOT_W-1:0] CLEAR_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] MARK_LIMIT = SLOT_W'(NODE_COUNT);
  localparam logic [8:0]        ALPHA_LIM  = 9'(ALPHABET_SIZE);

  // Node pool storage
  logic [NODE_W-1:0] child_mem [SLOTS];
  logic              mark_mem  [NODE_COUNT];

  // Walk state
  req_t              item;
  logic [SLOT_W-1:0] slot_q;
  logic              step;
  logic              brk_step;
  logic [NODE_W-1:0] cur;
  logic [NODE_W:0]   nf;
  logic              broken;
  logic              ovf;
  logic [SLOT_W-1:0] clr_cnt;
  logic [NODE_W-1:0] child_q;
  logic              mark_q;

  // Combinational signals
  logic              in_range;
  logic              step_ok;
  logic [SLOT_W-1:0] slot_addr;
  logic [NODE_W-1:0] cur_next;
  logic [NODE_W:0]   nf_next;
  logic              broken_next;
  logic              ovf_next;
  logic              alloc;
  logic              fin_found;
  logic              fin_full;
  logic              mark_set;
  logic              c_we;
  logic [SLOT_W-1:0] c_waddr;
  logic [NODE_W-1:0] c_wdata;
  logic              m_we;
  logic [NODE_W-1:0] m_waddr;
  logic              m_wdata;

  // Check the letter and form the child slot address of the current node
  assign in_range  = {4'b0, req_data.letter} < ALPHA_LIM;
  assign step_ok   = !req_data.empty_word && !broken && in_range;
  assign slot_addr = SLOT_W'(cur) * ALPHA_SLOT + SLOT_W'(req_data.letter);

  // Take one step from the child entry read at load
  always_comb begin
    cur_next    = cur;
    nf_next     = nf;
    broken_next = broken;
    ovf_next    = ovf;
    alloc       = 1'b0;
    if (step) begin
      if (child_q != '0) begin
        cur_next = child_q;
      end else if (item.operation == OP_INSERT) begin
        if (nf < NODE_LIMIT) begin
          alloc    = 1'b1;
          cur_next = nf[NODE_W-1:0];
          nf_next  = nf + 1'b1;
        end else begin
          ovf_next    = 1'b1;
          broken_next = 1'b1;
        end
      end else begin
        broken_next = 1'b1;
      end
    end
    if (brk_step) begin
      broken_next = 1'b1;
    end
  end

  // Form the result of a finished word
  always_comb begin
    fin_found = 1'b0;
    fin_full  = 1'b0;
    mark_set  = 1'b0;
    case (item.operation)
      OP_INSERT: begin
        fin_found = !broken;
        fin_full  = ovf;
        mark_set  = !broken;
      end
      OP_SEARCH: begin
        fin_found = !broken && mark_q;
      end
      OP_PREFIX: begin
        fin_found = !broken;
      end
      default: begin
        fin_found = 1'b0;
      end
    endcase
  end

  // Select memory write ports: clearing pass or normal operation
  assign c_we    = cmd.clear || (cmd.walk && alloc);
  assign c_waddr = cmd.clear ? clr_cnt : slot_q;
  assign c_wdata = cmd.clear ? '0 : nf[NODE_W-1:0];
  assign m_we    = (cmd.clear && (clr_cnt < MARK_LIMIT)) || (cmd.finish && mark_set);
  assign m_waddr = cmd.clear ? clr_cnt[NODE_W-1:0] : cur;
  assign m_wdata = !cmd.clear;

  // Child table memory: one write and one registered read
  always_ff @(posedge clk) begin
    if (c_we) begin
      child_mem[c_waddr] <= c_wdata;
    end
    if (cmd.load && step_ok) begin
      child_q <= child_mem[slot_addr];
    end
  end

  // End-of-word mark memory: read the node reached by this step
  always_ff @(posedge clk) begin
    if (m_we) begin
      mark_mem[m_waddr] <= m_wdata;
    end
    if (cmd.walk) begin
      mark_q <= mark_mem[cur_next];
    end
  end

  // Latch the request payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item   <= req_data;
      slot_q <= slot_addr;
    end
  end

  // Advance walk control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= '0;
      nf       <= (NODE_W + 1)'(1);
      broken   <= 1'b0;
      ovf      <= 1'b0;
      step     <= 1'b0;
      brk_step <= 1'b0;
      clr_cnt  <= '0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.load) begin
        step     <= step_ok;
        brk_step <= !req_data.empty_word && !broken && !in_range;
      end
      if (cmd.walk) begin
        cur    <= cur_next;
        nf     <= nf_next;
        broken <= broken_next;
        ovf    <= ovf_next;
      end else if (cmd.finish) begin
        cur    <= '0;
        broken <= 1'b0;
        ovf    <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_data.found     <= fin_found;
      rsp_data.pool_full <= fin_full;
    end
  end

  assign status.clear_done = clr_cnt == CLEAR_LAST;
  assign status.item_last  = item.last;
  assign status.out_free   = !rsp_valid || !rsp_stall;

  // Free pointer stays between one and the pool size
  a_nf_range: assert property (@(posedge clk) disable iff (rst)
    (nf != '0) && (nf <= NODE_LIMIT))
    else $error("free node pointer out of range");

  // The walk only visits allocated nodes
  a_cur_alloc: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur} < nf)
    else $error("current node not allocated");

  // A finished word returns the walk to a clean root
  a_finish_root: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (cur == '0) && !broken && !ovf && rsp_valid)
    else $error("walk not reset after result");

  // Allocation only happens on insert steps
  a_alloc_insert: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && alloc) |-> (item.operation == OP_INSERT) && step)
    else $error("allocation outside an insert step");

endmodule

`default_nettype wire

// File: rtl/prefix_tree_insert_search_top.sv
// Top level of the prefix tree insert and search block.
`timescale 1ns / 1ps
`default_nettype none

// Prefix tree over a letter alphabet held in a pool of NODE_COUNT nodes, one
// letter per request with an operation (insert, search, prefix query), a last
// flag and an empty-word flag; one result comes back on the last request of a
// word. After reset the block runs a clearing pass over the child table (the
// mark memory is cleared in the same pass) and stalls requests until it ends.
// Each letter then passes through a registered read of the current node's
// child entry, then the step with a possible child write. The last letter of
// a word also enters a finish state in which the end-of-word mark read in the
// step is used and the result register is loaded. A waiting result does not
// block the next request; a following result waits only while the previous
// one is still stalled.
module prefix_tree_insert_search_top #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire pti_pkg::req_t  req_data,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output pti_pkg::rsp_t       rsp_data
);
  import pti_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the work
  pti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the tree and walk it
  pti_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

// File: verif/prefix_tree_insert_search_top_tb.sv
// Testbench for the prefix tree insert and search block: stimulus, predictor and checks.
`timescale 1ns / 1ps

module prefix_tree_insert_search_top_tb;
  import pti_pkg::*;

  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_LEN       = 17;
  localparam int LIB_DEPTH     = 512;
  localparam int TOTAL_ITEMS   = 1650;
  localparam int POST_FILL_MIN = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 28;
  // clearing pass after reset covers all NODE_COUNT * ALPHABET_SIZE child slots
  localparam int WATCHDOG_LIMIT = 4 * NODE_COUNT * ALPHABET_SIZE;
  localparam int DRAIN_CYCLES  = 20;
  // spare operation code: walks like a search, never reports a hit
  localparam logic [1:0] OP_NONE = 2'd3;

  // Predict word results from the letters the block accepts and check them.
  class trie_checker;
    logic [9:0]  child_tbl [NODE_COUNT*ALPHABET_SIZE];
    bit          word_mark [NODE_COUNT];
    logic [10:0] free_node;
    logic [9:0]  cur_node;
    bit          broken;
    bit          overflowed;
    rsp_t        pending_answers[$];
    int          failures;
    int          words_checked;
    int          hits;
    int          full_answers;

    function new();
      foreach (child_tbl[i]) child_tbl[i] = '0;
      foreach (word_mark[i]) word_mark[i] = 1'b0;
      free_node = 11'd1;
      cur_node = '0;
      broken = 1'b0;
      overflowed = 1'b0;
      failures = 0;
      words_checked = 0;
      hits = 0;
      full_answers = 0;
    endfunction

    // Walk one letter, and on the last letter queue the word's answer.
    function void take_letter(req_t r);
      rsp_t ans;
      int slot;
      logic [9:0] child;
      if (!r.empty_word && !broken) begin
        if (r.letter >= ALPHABET_SIZE) begin
          broken = 1'b1;
        end else begin
          slot = int'(cur_node) * ALPHABET_SIZE + int'(r.letter);
          child = child_tbl[slot];
          if (child != '0) begin
            cur_node = child;
          end else if (r.operation != OP_INSERT) begin
            broken = 1'b1;
          end else if (free_node < NODE_COUNT) begin
            child_tbl[slot] = free_node[9:0];
            cur_node = free_node[9:0];
            free_node = free_node + 11'd1;
          end else begin
            overflowed = 1'b1;
            broken = 1'b1;
          end
        end
      end
      if (r.last) begin
        ans = '0;
        case (r.operation)
          OP_INSERT: begin
            if (!broken) begin
              word_mark[cur_node] = 1'b1;
              ans.found = 1'b1;
            end
            ans.pool_full = overflowed;
          end
          OP_SEARCH: if (!broken) ans.found = word_mark[cur_node];
          OP_PREFIX: ans.found = !broken;
          default: ;
        endcase
        pending_answers.push_back(ans);
        cur_node = '0;
        broken = 1'b0;
        overflowed = 1'b0;
      end
    endfunction

    // Compare one result with the oldest queued answer.
    function void check_answer(rsp_t got);
      rsp_t want;
      if (pending_answers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] unexpected result found=%0b pool_full=%0b", $realtime,
                   got.found, got.pool_full);
      end else begin
        want = pending_answers.pop_front();
        words_checked++;
        if (want.found) hits++;
        if (want.pool_full) full_answers++;
        if (got.found !== want.found || got.pool_full !== want.pool_full) begin
          failures++;
          if (failures <= 10)
            $display("[%0t] word %0d mismatch: found exp %0b got %0b, pool_full exp %0b got %0b",
                     $realtime, words_checked, want.found, got.found,
                     want.pool_full, got.pool_full);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp_data;

  trie_checker chk = new();

  int   items_sent;
  bit   calm;
  bit   hold_done;
  logic [4:0] word_buf [MAX_LEN];
  int   word_len;
  logic [4:0] lib_word [LIB_DEPTH][MAX_LEN];
  int   lib_len [LIB_DEPTH];
  int   lib_count;

  prefix_tree_insert_search_top #(
    .NODE_COUNT   (NODE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe both handshakes at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) chk.check_answer(rsp_data);
      if (req_valid && !req_stall) chk.take_letter(req_data);
    end
  end

  // End the run when nothing has moved for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no request or result moved in %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Stall results at random; hold off once for a long stretch to back up requests.
  initial begin
    rsp_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && !calm && chk.words_checked >= 30) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  function automatic req_t pack_req(logic [1:0] op, logic [4:0] letter, logic last,
                                    logic empty_word);
    req_t r;
    r.operation = op;
    r.letter = letter;
    r.last = last;
    r.empty_word = empty_word;
    return r;
  endfunction

  function automatic logic [1:0] query_op();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return OP_INSERT;
    if (pick <= 5) return OP_SEARCH;
    return OP_PREFIX;
  endfunction

  // Offer one request from a falling edge and hold it until accepted.
  task automatic send_item(req_t item);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= item;
    do @(posedge clk); while (req_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Send word_buf as one word; optionally mix operations or slip in empty requests.
  task automatic send_word(logic [1:0] op, bit mixed, bit empties);
    logic [1:0] step_op;
    if (word_len == 0) begin
      send_item(pack_req(op, 5'($urandom_range(0, 31)), 1'b1, 1'b1));
    end else begin
      for (int i = 0; i < word_len; i++) begin
        if (empties && $urandom_range(0, 3) == 0)
          send_item(pack_req(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                             1'b0, 1'b1));
        step_op = (mixed && i != word_len - 1) ? 2'($urandom_range(0, 3)) : op;
        send_item(pack_req(step_op, word_buf[i], i == word_len - 1, 1'b0));
      end
    end
  endtask

  task automatic make_random_word(int lo, int hi);
    word_len = $urandom_range(lo, hi);
    for (int i = 0; i < word_len; i++) word_buf[i] = 5'($urandom_range(0, 25));
  endtask

  // Copy a stored word, then maybe cut it, extend it or change one letter.
  task automatic load_lib_word();
    int idx;
    idx = $urandom_range(0, lib_count - 1);
    word_len = lib_len[idx];
    for (int i = 0; i < word_len; i++) word_buf[i] = lib_word[idx][i];
    case ($urandom_range(0, 3))
      1: word_len = $urandom_range(1, word_len);
      2: if (word_len < MAX_LEN) begin
        word_buf[word_len] = 5'($urandom_range(0, 25));
        word_len++;
      end
      3: word_buf[$urandom_range(0, word_len - 1)] = 5'($urandom_range(0, 25));
      default: ;
    endcase
  endtask

  task automatic insert_new_word(int lo, int hi);
    int idx;
    make_random_word(lo, hi);
    send_word(OP_INSERT, 1'b0, 1'b0);
    if (lib_count < LIB_DEPTH) begin
      idx = lib_count;
      lib_count++;
    end else begin
      idx = $urandom_range(0, LIB_DEPTH - 1);
    end
    lib_len[idx] = word_len;
    for (int i = 0; i < word_len; i++) lib_word[idx][i] = word_buf[i];
  endtask

  // Unusual words: empty, mixed operations, spare code, bad letters, empty requests inside.
  task automatic send_odd_word();
    case ($urandom_range(0, 4))
      0: begin
        word_len = 0;
        send_word(2'($urandom_range(0, 3)), 1'b0, 1'b0);
      end
      1: begin
        if (lib_count > 0) load_lib_word();
        else make_random_word(1, 6);
        send_word(2'($urandom_range(0, 2)), 1'b1, 1'b0);
      end
      2: begin
        make_random_word(1, 6);
        send_word(OP_NONE, 1'b0, 1'b0);
      end
      3: begin
        make_random_word(1, 6);
        word_buf[$urandom_range(0, word_len - 1)] = 5'($urandom_range(ALPHABET_SIZE, 31));
        send_word(2'($urandom_range(0, 2)), 1'b0, 1'b0);
      end
      default: begin
        if (lib_count > 0) load_lib_word();
        else make_random_word(1, 6);
        send_word(2'($urandom_range(0, 2)), 1'b0, 1'b1);
      end
    endcase
  endtask

  initial begin
    int pick;
    int after_fill;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    items_sent = 0;
    lib_count = 0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: empty words, letter extremes, bad letters, spare code, mixing
    send_item(pack_req(OP_SEARCH, 5'd0, 1'b1, 1'b1));
    send_item(pack_req(OP_PREFIX, 5'd31, 1'b1, 1'b1));
    send_item(pack_req(OP_INSERT, 5'd0, 1'b1, 1'b1));
    send_item(pack_req(OP_SEARCH, 5'd31, 1'b1, 1'b1));
    send_item(pack_req(OP_INSERT, 5'd0, 1'b0, 1'b0));
    send_item(pack_req(OP_INSERT, 5'd25, 1'b1, 1'b0));
    send_item(pack_req(OP_SEARCH, 5'd0, 1'b0, 1'b0));
    send_item(pack_req(OP_SEARCH, 5'd25, 1'b1, 1'b0));
    send_item(pack_req(OP_SEARCH, 5'd0, 1'b1, 1'b0));
    send_item(pack_req(OP_PREFIX, 5'd0, 1'b1, 1'b0));
    send_item(pack_req(OP_INSERT, 5'd0, 1'b0, 1'b0));
    send_item(pack_req(OP_INSERT, 5'd31, 1'b1, 1'b0));
    send_item(pack_req(OP_SEARCH, 5'd0, 1'b0, 1'b0));
    send_item(pack_req(OP_PREFIX, 5'd7, 1'b0, 1'b1));
    send_item(pack_req(OP_SEARCH, 5'd25, 1'b1, 1'b0));
    send_item(pack_req(OP_NONE, 5'd0, 1'b0, 1'b0));
    send_item(pack_req(OP_NONE, 5'd25, 1'b1, 1'b0));
    send_item(pack_req(OP_INSERT, 5'd1, 1'b0, 1'b0));
    send_item(pack_req(OP_SEARCH, 5'd2, 1'b1, 1'b0));
    send_item(pack_req(OP_PREFIX, 5'd1, 1'b1, 1'b0));
    send_item(pack_req(OP_PREFIX, 5'd26, 1'b1, 1'b0));

    // Fill the node pool with long new words, mixed with queries and odd words
    while (chk.free_node < NODE_COUNT && items_sent < 3000) begin
      calm = (items_sent >= 600 && items_sent < 800);
      pick = (lib_count == 0) ? 0 : $urandom_range(0, 99);
      if (pick < 80) insert_new_word(8, 14);
      else if (pick < 93) begin
        load_lib_word();
        send_word(query_op(), 1'b0, 1'b0);
      end else send_odd_word();
    end

    // Pool exhausted: queries over stored words, failing inserts, odd words
    after_fill = items_sent;
    while (items_sent < TOTAL_ITEMS || items_sent < after_fill + POST_FILL_MIN) begin
      calm = (items_sent >= 600 && items_sent < 800);
      pick = $urandom_range(0, 99);
      if (pick < 25) insert_new_word(3, 8);
      else if (pick < 80) begin
        load_lib_word();
        send_word(query_op(), 1'b0, 1'b0);
      end else send_odd_word();
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // Drain outstanding results, then keep watching for stray ones
    while (chk.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d letter requests; checked %0d word results, %0d hits, %0d pool-full.",
             items_sent, chk.words_checked, chk.hits, chk.full_answers);
    $display("Tree grew to %0d of %0d nodes; long result hold-off done: %0d; failures: %0d.",
             chk.free_node, NODE_COUNT, hold_done, chk.failures);
    if (chk.failures == 0 && chk.pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: prefix_tree_insert_search_top.f
rtl/pti_pkg.sv
rtl/pti_ctrl.sv
rtl/pti_datapath.sv
rtl/prefix_tree_insert_search_top.sv
verif/prefix_tree_insert_search_top_tb.sv
